@@ rtl/sphi_pkg.sv @@
// Package for the string polynomial hash index block.
// Holds register indexes, reset values and field widths; no dependencies.
package sphi_pkg;

  localparam int HashW   = 32;
  localparam int SizeW   = 31;
  localparam int ByteW   = 8;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 32;

  localparam logic [CfgIdxW-1:0] RegMultiplier = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTableSize  = 1'b1;

  localparam logic [HashW-1:0] MultiplierReset = 32'd31;
  localparam logic [SizeW-1:0] TableSizeReset  = 31'd1024;

  typedef logic [HashW-1:0] hash_t;

endpackage

@@ rtl/string_polynomial_hash_index_top.sv @@
// Top level of the string polynomial hash index block.
// Depends on sphi_pkg for register indexes, reset values and widths.
//
// Bytes of a string arrive one per transaction; each non-zero byte is folded
// into a 32-bit running hash as hash*multiplier + byte in the cycle it is
// accepted, so bytes before the last one are taken at one per cycle. The
// transaction carrying tlast ends the string: the final hash is then reduced
// modulo table_size by one restoring subtract-and-compare unit that produces
// one remainder bit per cycle, so a last byte occupies the block through its
// 32 reduction steps before the next byte is taken. The result sits in an
// output register, so bytes of the next string may be accepted while it
// waits to be taken; a reduction that completes while the register is still
// full waits for it to drain. A table size of zero gives bucket index zero.
module string_polynomial_hash_index_top (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write port
  input  logic                         cfg_we,
  input  logic [sphi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sphi_pkg::CfgW-1:0]    cfg_data,
  // Input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] char_byte
  input  logic                         s_tlast,   // last
  // Output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [63:0]                  m_tdata    // [30:0] bucket_index, [62:31] full_hash
);
  import sphi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  localparam int CntW = $clog2(HashW);

  logic [1:0]       state;
  hash_t            multiplier;
  logic [SizeW-1:0] table_size;
  hash_t            running_hash;
  hash_t            full_hash;
  hash_t            shift_hash;
  hash_t            rem;
  logic [CntW-1:0]  cnt;
  logic [SizeW-1:0] out_index;
  hash_t            out_hash;
  logic             out_valid;

  hash_t            folded;
  hash_t            rem_shift;
  logic [HashW:0]   diff;
  hash_t            rem_next;
  logic             accept;
  logic             div_done;
  logic             out_free;

  // Multiply-add of one byte; a zero byte leaves the hash untouched.
  always_comb begin
    if (s_tdata == '0) begin
      folded = running_hash;
    end else begin
      folded = running_hash * multiplier + {{(HashW-ByteW){1'b0}}, s_tdata};
    end
  end

  // One restoring step of the remainder.
  assign rem_shift = {rem[HashW-2:0], shift_hash[HashW-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, table_size};
  assign rem_next  = diff[HashW] ? rem_shift : diff[HashW-1:0];

  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign div_done = (state == S_DIV) && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MultiplierReset;
      table_size <= TableSizeReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegMultiplier: multiplier <= cfg_data;
        RegTableSize:  table_size <= cfg_data[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_hash <= '0;
      cnt          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tlast) begin
              running_hash <= '0;
              state        <= S_DIV;
              cnt          <= CntW'(HashW - 1);
            end else begin
              running_hash <= folded;
            end
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= out_free ? S_IDLE : S_HOLD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath of the reduction unit.
  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      full_hash  <= folded;
      shift_hash <= folded;
      rem        <= '0;
    end else if (state == S_DIV) begin
      shift_hash <= {shift_hash[HashW-2:0], 1'b0};
      rem        <= rem_next;
    end
  end

  // Output register; loaded at the end of a reduction or from the hold state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((div_done || state == S_HOLD) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done && out_free) begin
      out_hash  <= full_hash;
      out_index <= (table_size == '0) ? '0 : rem_next[SizeW-1:0];
    end else if (state == S_HOLD && out_free) begin
      out_hash  <= full_hash;
      out_index <= (table_size == '0) ? '0 : rem[SizeW-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_hash, out_index};

  // The bucket index lies within the table whenever the table size is non-zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && table_size != '0) |-> (out_index < table_size))
    else $error("bucket index not below table size");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && table_size == '0) |-> (out_index == '0))
    else $error("bucket index not zero for empty table");

  // A last byte always starts a reduction and blocks further input.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (state == S_DIV && !s_tready))
    else $error("last byte did not start the reduction");

  // The reduction result lands in the output register once it is free.
  assert property (@(posedge clk) disable iff (rst)
    (div_done && out_free) |=> (m_tvalid && state == S_IDLE))
    else $error("finished reduction not presented");

endmodule
